// File: hdl/transformed_bounding_box_macros.svh
// Assertion macros for the bounding box RTL.
`ifndef TRANSFORMED_BOUNDING_BOX_MACROS_SVH
`define TRANSFORMED_BOUNDING_BOX_MACROS_SVH

`ifndef ASSERT_OFF
// General property check, disabled while reset is high
`define TBB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen at a clock edge
`define TBB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TBB_ASSERT(label, clk, rst, prop, msg)
`define TBB_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// File: hdl/tbb_pkg.sv
`default_nettype none

package tbb_pkg;

   // Field widths
   localparam int unsigned COORD_W    = 32;
   localparam int unsigned COEF_W     = 20;
   localparam int unsigned ROW_W      = 3 * COEF_W;
   localparam int unsigned FRAC_SHIFT = 14;
   localparam int unsigned PROD_W     = COEF_W + COORD_W;
   localparam int unsigned SUM_W      = PROD_W + 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = ROW_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X_COEFFS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y_COEFFS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z_COEFFS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z     = 3'd5;

   // 1.0 in Q6.14 and one half LSB of the Q16.16 result in Q*.30
   localparam logic [COEF_W-1:0]       COEF_ONE   = 20'd16384;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = 56'sd8192;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_vertex;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [COORD_W-1:0]        extent_x;
      logic [COORD_W-1:0]        extent_y;
      logic [COORD_W-1:0]        extent_z;
   } rsp_payload_type;

   // Transformed vertex, axis 0 is x
   typedef struct packed {
      logic                     last;
      logic [2:0][COORD_W-1:0]  coord;
   } vertex_type;

   typedef struct packed {
      logic       valid;
      vertex_type data;
   } queue_head_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } front_status_type;

   // Signed 20 x 32 product, operands sign extended to the product width
   function automatic logic signed [PROD_W-1:0] mul_coef(input logic [COEF_W-1:0] c,
                                                         input logic [COORD_W-1:0] p);
      logic signed [PROD_W-1:0] ce;
      logic signed [PROD_W-1:0] pe;
      ce = $signed({{(PROD_W-COEF_W){c[COEF_W-1]}}, c});
      pe = $signed({{(PROD_W-COORD_W){p[COORD_W-1]}}, p});
      return ce * pe;
   endfunction

endpackage

`default_nettype wire

// File: hdl/tbb_front.sv
`default_nettype none

// Front end: holds the matrix, transforms accepted vertices in a
// two-register pipeline and pushes the rounded, saturated result.
module tbb_front import tbb_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire req_payload_type        req_payload,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic                        push_valid,
   output vertex_type                  push_data,
   output front_status_type            status
);

   logic [2:0][ROW_W-1:0]   row_coeffs_ff;
   logic [2:0][COORD_W-1:0] offset_ff;

   logic                     s1_valid_ff;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] s1_prod_ff [3][3];
   logic signed [PROD_W-1:0] s1_prod_in [3][3];

   logic                     s2_valid_ff;
   logic                     s2_last_ff;
   logic signed [SUM_W-1:0]  s2_sum_ff [3];
   logic signed [SUM_W-1:0]  s2_sum_in [3];

   logic [2:0][COORD_W-1:0]  point;
   logic [2:0][COORD_W-1:0]  sat_coord;

   // Configuration registers, identity matrix after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_coeffs_ff[0] <= {{(2*COEF_W){1'b0}}, COEF_ONE};
         row_coeffs_ff[1] <= {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}};
         row_coeffs_ff[2] <= {COEF_ONE, {(2*COEF_W){1'b0}}};
         offset_ff        <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_X_COEFFS: row_coeffs_ff[0] <= csr_data;
            CSR_ROW_Y_COEFFS: row_coeffs_ff[1] <= csr_data;
            CSR_ROW_Z_COEFFS: row_coeffs_ff[2] <= csr_data;
            CSR_OFFSET_X:     offset_ff[0]     <= csr_data[COORD_W-1:0];
            CSR_OFFSET_Y:     offset_ff[1]     <= csr_data[COORD_W-1:0];
            CSR_OFFSET_Z:     offset_ff[2]     <= csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   assign point[0] = req_payload.point_x;
   assign point[1] = req_payload.point_y;
   assign point[2] = req_payload.point_z;

   // Stage 1: nine coefficient products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s1_prod_in[r][c] = mul_coef(row_coeffs_ff[r][c*COEF_W +: COEF_W], point[c]);
         end
      end
   end

   // Stage 2: row sum plus offset and rounding half
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s2_sum_in[r] = $signed({{(SUM_W-PROD_W){s1_prod_ff[r][0][PROD_W-1]}},
                                 s1_prod_ff[r][0]})
                      + $signed({{(SUM_W-PROD_W){s1_prod_ff[r][1][PROD_W-1]}},
                                 s1_prod_ff[r][1]})
                      + $signed({{(SUM_W-PROD_W){s1_prod_ff[r][2][PROD_W-1]}},
                                 s1_prod_ff[r][2]})
                      + $signed({{(SUM_W-COORD_W-FRAC_SHIFT){offset_ff[r][COORD_W-1]}},
                                 offset_ff[r], {FRAC_SHIFT{1'b0}}})
                      + ROUND_HALF;
      end
   end

   // Floor shift and saturate to 32 bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (s2_sum_ff[r][SUM_W-1:FRAC_SHIFT+COORD_W-1] == '0 ||
             s2_sum_ff[r][SUM_W-1:FRAC_SHIFT+COORD_W-1] == '1) begin
            sat_coord[r] = s2_sum_ff[r][FRAC_SHIFT +: COORD_W];
         end else if (s2_sum_ff[r][SUM_W-1]) begin
            sat_coord[r] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            sat_coord[r] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_last_ff <= req_payload.last_vertex;
      s1_prod_ff <= s1_prod_in;
      s2_last_ff <= s1_last_ff;
      s2_sum_ff  <= s2_sum_in;
   end

   assign push_valid      = s2_valid_ff;
   assign push_data.last  = s2_last_ff;
   assign push_data.coord = sat_coord;
   assign status.s1_valid = s1_valid_ff;
   assign status.s2_valid = s2_valid_ff;

endmodule

`default_nettype wire

// File: hdl/tbb_queue.sv
`default_nettype none

// Small first-word-fall-through queue of transformed vertices.
module tbb_queue import tbb_pkg::*; #(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire vertex_type                  push_data,
   input  wire logic                        pop,
   output queue_head_type                   head,
   output logic                             full,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   vertex_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign count      = count_ff;

endmodule

`default_nettype wire

// File: hdl/tbb_back.sv
`default_nettype none

// Back end: running min/max per axis, emits center and size on the last vertex.
module tbb_back import tbb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire queue_head_type    head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_payload_type        rsp_payload
);

   logic                    box_empty_ff;
   logic [2:0][COORD_W-1:0] low_ff;
   logic [2:0][COORD_W-1:0] low_in;
   logic [2:0][COORD_W-1:0] high_ff;
   logic [2:0][COORD_W-1:0] high_in;
   logic [2:0][COORD_W-1:0] center;
   logic [2:0][COORD_W-1:0] extent;
   logic [COORD_W:0]        pair_sum [3];

   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;
   rsp_payload_type         rsp_payload_in;
   logic                    out_free;

   // A last vertex needs the output register; others pass regardless
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && (!head.data.last || out_free);

   // Box update, seeded when empty
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (box_empty_ff) begin
            low_in[a]  = head.data.coord[a];
            high_in[a] = head.data.coord[a];
         end else begin
            low_in[a]  = ($signed(head.data.coord[a]) < $signed(low_ff[a])) ?
                         head.data.coord[a] : low_ff[a];
            high_in[a] = ($signed(head.data.coord[a]) > $signed(high_ff[a])) ?
                         head.data.coord[a] : high_ff[a];
         end
         pair_sum[a] = {low_in[a][COORD_W-1], low_in[a]} +
                       {high_in[a][COORD_W-1], high_in[a]};
         center[a]   = pair_sum[a][COORD_W:1];
         extent[a]   = high_in[a] - low_in[a];
      end
   end

   always_comb begin
      rsp_payload_in.center_x = center[0];
      rsp_payload_in.center_y = center[1];
      rsp_payload_in.center_z = center[2];
      rsp_payload_in.extent_x = extent[0];
      rsp_payload_in.extent_y = extent[1];
      rsp_payload_in.extent_z = extent[2];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         box_empty_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            box_empty_ff <= head.data.last;
         end
         if (pop && head.data.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Box bounds and result register
   always_ff @(posedge clock) begin
      if (pop) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
      if (pop && head.data.last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: hdl/transformed_bounding_box.sv
// Path from the taken last vertex to rsp_valid: transform registers s1 and s2, the queue, then the result register.
// Throughput: one vertex per cycle while req_stall is low; req_stall rises once QUEUE_DEPTH transactions sit
// in the transform pipeline and the queue, i.e. when the result side holds back.
// Reset (synchronous, active high): identity matrix, zero offsets, empty box,
// transform pipeline valids, queue and result valid flag cleared.
`default_nettype none
`include "transformed_bounding_box_macros.svh"

module transformed_bounding_box import tbb_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

   logic             req_accept;
   logic             q_push;
   vertex_type       q_push_data;
   logic             q_pop;
   logic             q_full;
   logic [CNT_W-1:0] q_count;
   queue_head_type   q_head;
   front_status_type front_status;
   logic [CNT_W-1:0] slots_used;

   // Slots taken in the pipeline plus the queue
   logic [CNT_W-1:0] credit_ff;
   logic [CNT_W-1:0] credit_in;

   assign req_stall  = (credit_ff == CNT_W'(QUEUE_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign credit_in  = credit_ff + CNT_W'(req_accept) - CNT_W'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   tbb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_payload (req_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push_valid  (q_push),
      .push_data   (q_push_data),
      .status      (front_status)
   );

   tbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .count     (q_count)
   );

   tbb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Occupancy seen by the pipeline stages and the queue
   assign slots_used = q_count + CNT_W'(front_status.s1_valid) + CNT_W'(front_status.s2_valid);

   // Checks
   `TBB_ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_full && !q_pop, "queue overflow")
   `TBB_ASSERT_NEVER(a_queue_underflow, clock, reset, q_pop && !q_head.valid, "queue underflow")
   `TBB_ASSERT(a_credit_match, clock, reset, credit_ff == slots_used, "credit out of step")

endmodule

`default_nettype wire
